// ----- src/htip_pkg.sv -----
// Shared types and constants of the hex text image parser.
`default_nettype none

package htip_pkg;

    localparam int MaxLineBytes  = 64;
    localparam int AddressBits   = 32;
    // Widest values that the parameters may reach; the command carries these widths.
    localparam int AddrMaxBits   = 64;
    localparam int CountMaxBits  = 9;

    localparam logic [1:0] StatusData   = 2'd0;
    localparam logic [1:0] StatusDigits = 2'd1;
    localparam logic [1:0] StatusBytes  = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_stream;
    } item_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] byte_address;
        logic [7:0]  byte_value;
        logic        last_of_line;
    } result_t;

    // One finished line handed from the parser to the emitter.
    typedef struct packed {
        logic                     is_err;
        logic [1:0]               status;
        logic [AddrMaxBits-1:0]   addr;
        logic [CountMaxBits-1:0]  count;
        logic                     bank;
    } cmd_t;

endpackage

`default_nettype wire

// ----- src/htip_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module htip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AddrBits = $clog2(DEPTH)
) (
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [AddrBits-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]    wr_data,
    input  wire logic                rd_en,
    input  wire logic [AddrBits-1:0] rd_addr,
    output logic      [WIDTH-1:0]    rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/htip_front.sv -----
// Character classifier: tracks the line, stores data bytes and issues line commands.
`default_nettype none

module htip_front import htip_pkg::*; #(
    parameter int MAX_LINE_BYTES = MaxLineBytes,
    parameter int ADDRESS_BITS   = AddressBits,
    localparam int IdxBits = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1,
    localparam int CntBits = $clog2(MAX_LINE_BYTES + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire item_in_t         char_data,
    input  wire logic             char_valid,
    output logic                  char_stall,
    output cmd_t                  cmd,
    output logic                  cmd_push,
    input  wire logic             cmd_full,
    output logic                  wr_en,
    output logic [IdxBits:0]      wr_addr,
    output logic [7:0]            wr_data,
    input  wire logic             release_bank
);

    localparam logic [7:0] CharAt      = 8'h40;
    localparam logic [7:0] CharZero    = 8'h30;
    localparam logic [7:0] CharNine    = 8'h39;
    localparam logic [7:0] CharUpA     = 8'h41;
    localparam logic [7:0] CharUpF     = 8'h46;
    localparam logic [7:0] CharLowA    = 8'h61;
    localparam logic [7:0] CharLowF    = 8'h66;
    localparam logic [7:0] CharSpace   = 8'h20;
    localparam logic [7:0] CharTab     = 8'h09;
    localparam logic [7:0] CharNewline = 8'h0A;
    localparam logic [7:0] CharVtab    = 8'h0B;
    localparam logic [7:0] CharFeed    = 8'h0C;
    localparam logic [7:0] CharReturn  = 8'h0D;

    localparam logic [1:0] PhaseFirst  = 2'd0;
    localparam logic [1:0] PhaseDigits = 2'd1;
    localparam logic [1:0] PhaseTrail  = 2'd2;
    localparam logic [1:0] ErrNone     = 2'd0;
    localparam logic [1:0] BanksAll    = 2'd2;

    logic                    flag_start_reg, flag_start_next;
    logic                    flag_addr_reg, flag_addr_next;
    logic                    flag_data_reg, flag_data_next;
    logic [1:0]              phase_reg, phase_next;
    logic [ADDRESS_BITS-1:0] acc_reg, acc_next;
    logic [ADDRESS_BITS-1:0] cur_reg, cur_next;
    logic [7:0]              val_reg, val_next;
    logic [1:0]              dcnt_reg, dcnt_next;
    logic [CntBits-1:0]      lcount_reg, lcount_next;
    logic [1:0]              err_reg, err_next;
    logic                    halted_reg, halted_next;
    logic                    wbank_reg, wbank_next;
    logic [1:0]              used_reg, used_next;

    assign char_stall = !halted_reg && ((used_reg == BanksAll) || cmd_full);

    always_comb
    begin
        logic [7:0] c;
        logic       is_hex;
        logic [3:0] hv;
        logic       is_ws;
        logic       ok;
        logic       push;
        logic       eol;
        logic       inc;

        c      = char_data.char_code;
        is_hex = 1'b1;
        hv     = 4'd0;
        if (c >= CharZero && c <= CharNine)
        begin
            hv = 4'(c - CharZero);
        end
        else if (c >= CharUpA && c <= CharUpF)
        begin
            hv = 4'(c - CharUpA + 8'd10);
        end
        else if (c >= CharLowA && c <= CharLowF)
        begin
            hv = 4'(c - CharLowA + 8'd10);
        end
        else
        begin
            is_hex = 1'b0;
        end
        is_ws = (c == CharSpace) || (c == CharTab) || (c == CharNewline) ||
                (c == CharVtab) || (c == CharFeed) || (c == CharReturn);
        eol   = (c == CharNewline) || char_data.end_of_stream;
        ok    = 1'b1;
        push  = 1'b0;
        inc   = 1'b0;

        flag_start_next = flag_start_reg;
        flag_addr_next  = flag_addr_reg;
        flag_data_next  = flag_data_reg;
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        cur_next        = cur_reg;
        val_next        = val_reg;
        dcnt_next       = dcnt_reg;
        lcount_next     = lcount_reg;
        err_next        = err_reg;
        halted_next     = halted_reg;
        wbank_next      = wbank_reg;

        cmd_push    = 1'b0;
        cmd.is_err  = 1'b0;
        cmd.status  = StatusData;
        cmd.addr    = AddrMaxBits'(cur_reg);
        cmd.count   = CountMaxBits'(lcount_reg);
        cmd.bank    = wbank_reg;

        wr_en   = 1'b0;
        wr_addr = {wbank_reg, lcount_reg[IdxBits-1:0]};
        wr_data = val_reg;

        if (char_valid && !char_stall && !halted_reg)
        begin
            // Address line candidate: '@', hex digits, then whitespace only.
            if (flag_addr_reg)
            begin
                priority if (flag_start_reg)
                begin
                    ok = (c == CharAt);
                end
                else if (phase_reg == PhaseFirst)
                begin
                    if (is_hex)
                    begin
                        acc_next   = ADDRESS_BITS'(hv);
                        phase_next = PhaseDigits;
                    end
                    else
                    begin
                        ok = 1'b0;
                    end
                end
                else if (phase_reg == PhaseDigits)
                begin
                    if (is_hex)
                    begin
                        acc_next = {acc_reg[ADDRESS_BITS-5:0], hv};
                    end
                    else if (is_ws)
                    begin
                        phase_next = PhaseTrail;
                    end
                    else
                    begin
                        ok = 1'b0;
                    end
                end
                else
                begin
                    ok = is_ws;
                end
                if (!ok)
                begin
                    flag_addr_next = 1'b0;
                end
            end

            // Data line candidate: values of hex digits split by whitespace.
            if (flag_data_reg)
            begin
                if (is_ws)
                begin
                    push = (dcnt_reg != 2'd0);
                end
                else if (is_hex)
                begin
                    if (dcnt_reg >= 2'd2)
                    begin
                        if (err_next == ErrNone)
                        begin
                            err_next = StatusDigits;
                        end
                    end
                    else
                    begin
                        val_next  = {val_reg[3:0], hv};
                        dcnt_next = dcnt_reg + 2'd1;
                    end
                end
                else
                begin
                    flag_data_next = 1'b0;
                end
            end

            // The line end closes a value that is still open.
            if (eol && flag_data_next && (dcnt_next != 2'd0))
            begin
                push = 1'b1;
            end

            if (push)
            begin
                wr_data = val_next;
                if (lcount_reg >= CntBits'(MAX_LINE_BYTES))
                begin
                    if (err_next == ErrNone)
                    begin
                        err_next = StatusBytes;
                    end
                end
                else
                begin
                    wr_en       = 1'b1;
                    lcount_next = lcount_reg + CntBits'(1);
                end
                val_next  = 8'd0;
                dcnt_next = 2'd0;
            end

            flag_start_next = 1'b0;

            if (eol)
            begin
                if (flag_addr_next && (phase_next != PhaseFirst))
                begin
                    cur_next = acc_next;
                end
                else if (flag_data_next)
                begin
                    if (err_next != ErrNone)
                    begin
                        cmd_push    = 1'b1;
                        cmd.is_err  = 1'b1;
                        cmd.status  = err_next;
                        halted_next = 1'b1;
                    end
                    else if (lcount_next != '0)
                    begin
                        cmd_push   = 1'b1;
                        cmd.count  = CountMaxBits'(lcount_next);
                        cur_next   = cur_reg + ADDRESS_BITS'(lcount_next);
                        wbank_next = ~wbank_reg;
                        inc        = 1'b1;
                    end
                end
                flag_start_next = 1'b1;
                flag_addr_next  = 1'b1;
                flag_data_next  = 1'b1;
                phase_next      = PhaseFirst;
                acc_next        = '0;
                val_next        = 8'd0;
                dcnt_next       = 2'd0;
                lcount_next     = '0;
                err_next        = ErrNone;
            end
        end

        unique case ({inc, release_bank})
            2'b10:   used_next = used_reg + 2'd1;
            2'b01:   used_next = used_reg - 2'd1;
            default: used_next = used_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_start_reg <= 1'b1;
            flag_addr_reg  <= 1'b1;
            flag_data_reg  <= 1'b1;
            phase_reg      <= PhaseFirst;
            acc_reg        <= '0;
            cur_reg        <= '0;
            val_reg        <= 8'd0;
            dcnt_reg       <= 2'd0;
            lcount_reg     <= '0;
            err_reg        <= ErrNone;
            halted_reg     <= 1'b0;
            wbank_reg      <= 1'b0;
            used_reg       <= 2'd0;
        end
        else
        begin
            flag_start_reg <= flag_start_next;
            flag_addr_reg  <= flag_addr_next;
            flag_data_reg  <= flag_data_next;
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            cur_reg        <= cur_next;
            val_reg        <= val_next;
            dcnt_reg       <= dcnt_next;
            lcount_reg     <= lcount_next;
            err_reg        <= err_next;
            halted_reg     <= halted_next;
            wbank_reg      <= wbank_next;
            used_reg       <= used_next;
        end
    end

`ifndef SYNTHESIS
    // A bank is never handed back unless one is held by the emitter.
    a_release_held: assert property (@(posedge clk) disable iff (!rst_n)
        release_bank |-> (used_reg != 2'd0))
        else $error("bank released while none is in use");
`endif

endmodule

`default_nettype wire

// ----- src/htip_cmd_queue.sv -----
// Two-entry queue of line commands between the parser and the emitter.
`default_nettype none

module htip_cmd_queue import htip_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t push_cmd,
    input  wire logic push,
    input  wire logic pop,
    output cmd_t      head,
    output logic      full,
    output logic      not_empty
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("line command pushed into a full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("line command popped from an empty queue");
`endif

endmodule

`default_nettype wire

// ----- src/htip_back.sv -----
// Emitter: replays a stored line from the buffer as result transactions.
`default_nettype none

module htip_back import htip_pkg::*; #(
    parameter int MAX_LINE_BYTES = MaxLineBytes,
    parameter int ADDRESS_BITS   = AddressBits,
    localparam int IdxBits = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1,
    localparam int CntBits = $clog2(MAX_LINE_BYTES + 1)
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    input  wire logic        cmd_valid,
    output logic             cmd_pop,
    output logic             rd_en,
    output logic [IdxBits:0] rd_addr,
    input  wire logic [7:0]  rd_data,
    output result_t          result_data,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             release_bank
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_READ = 3'b010,
        B_SHOW = 3'b100
    } back_state_t;

    back_state_t             state_reg, state_next;
    logic                    err_reg, err_next;
    logic [ADDRESS_BITS-1:0] addr_reg, addr_next;
    logic [CntBits-1:0]      count_reg, count_next;
    logic [CntBits-1:0]      idx_reg, idx_next;
    logic                    bank_reg, bank_next;
    result_t                 out_reg, out_next;
    logic [CntBits-1:0]      idx_inc;
    logic [AddrMaxBits-1:0]  addr_wide;

    assign idx_inc      = idx_reg + CntBits'(1);
    assign addr_wide    = AddrMaxBits'(addr_reg);
    assign result_data  = out_reg;
    assign result_valid = (state_reg == B_SHOW);

    always_comb
    begin
        state_next   = state_reg;
        err_next     = err_reg;
        addr_next    = addr_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        bank_next    = bank_reg;
        out_next     = out_reg;
        cmd_pop      = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = {bank_reg, idx_inc[IdxBits-1:0]};
        release_bank = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    err_next   = cmd.is_err;
                    addr_next  = cmd.addr[ADDRESS_BITS-1:0];
                    count_next = cmd.count[CntBits-1:0];
                    idx_next   = '0;
                    bank_next  = cmd.bank;
                    if (cmd.is_err)
                    begin
                        out_next.status       = cmd.status;
                        out_next.byte_address = cmd.addr[31:0];
                        out_next.byte_value   = 8'd0;
                        out_next.last_of_line = 1'b1;
                        state_next            = B_SHOW;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = {cmd.bank, {IdxBits{1'b0}}};
                        state_next = B_READ;
                    end
                end
            end
            B_READ:
            begin
                out_next.status       = StatusData;
                out_next.byte_address = addr_wide[31:0];
                out_next.byte_value   = rd_data;
                out_next.last_of_line = (idx_inc == count_reg);
                state_next            = B_SHOW;
            end
            B_SHOW:
            begin
                if (!result_stall)
                begin
                    if (err_reg || out_reg.last_of_line)
                    begin
                        release_bank = !err_reg;
                        state_next   = B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        addr_next  = addr_reg + ADDRESS_BITS'(1);
                        rd_en      = 1'b1;
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        addr_reg  <= addr_next;
        count_reg <= count_next;
        idx_reg   <= idx_next;
        bank_reg  <= bank_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // An error result always closes its line and carries no byte.
    a_error_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.status != StatusData) |->
            (result_data.last_of_line && result_data.byte_value == 8'd0))
        else $error("error result without line close");
`endif

endmodule

`default_nettype wire

// ----- src/hex_text_image_parser_unit.sv -----
// Throughput: one character per clock while the command queue has room and a line bank is free.
// A data line's bytes leave one at a time: each is read from the buffer RAM (B_READ), then
// held in the output register (B_SHOW) until result_stall is low; each line first fetches
// its command from the queue in B_IDLE. An error result goes from B_IDLE straight to B_SHOW.
// Reset (rst_n, asynchronous) clears all control state; the line buffer needs no clearing.
`default_nettype none

module hex_text_image_parser_unit import htip_pkg::*; #(
    parameter int MAX_LINE_BYTES = MaxLineBytes,
    parameter int ADDRESS_BITS   = AddressBits,
    localparam int IdxBits = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire item_in_t char_data,
    input  wire logic     char_valid,
    output logic          char_stall,
    output result_t       result_data,
    output logic          result_valid,
    input  wire logic     result_stall
);

    cmd_t             push_cmd;
    cmd_t             head_cmd;
    logic             cmd_push;
    logic             cmd_pop;
    logic             cmd_full;
    logic             cmd_ready;
    logic             wr_en;
    logic [IdxBits:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [IdxBits:0] rd_addr;
    logic [7:0]       rd_data;
    logic             release_bank;

    htip_front #(
        .MAX_LINE_BYTES(MAX_LINE_BYTES),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_data   (char_data),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .cmd         (push_cmd),
        .cmd_push    (cmd_push),
        .cmd_full    (cmd_full),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .release_bank(release_bank)
    );

    htip_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cmd (push_cmd),
        .push     (cmd_push),
        .pop      (cmd_pop),
        .head     (head_cmd),
        .full     (cmd_full),
        .not_empty(cmd_ready)
    );

    // Two banks: one line fills while the previous one is replayed.
    htip_ram #(
        .WIDTH(8),
        .DEPTH(2 * (2 ** IdxBits))
    ) u_line_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    htip_back #(
        .MAX_LINE_BYTES(MAX_LINE_BYTES),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (head_cmd),
        .cmd_valid   (cmd_ready),
        .cmd_pop     (cmd_pop),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .result_data (result_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .release_bank(release_bank)
    );

endmodule

`default_nettype wire
